@@ rtl/radial_basis_kernel_eval_defines.svh @@
// ----------------------------------------------------------------------------
// Radial basis kernel evaluator: assertion macros
// Shared property shorthands for the checker of the kernel evaluator.
// ----------------------------------------------------------------------------
`ifndef RADIAL_BASIS_KERNEL_EVAL_DEFINES_SVH
`define RADIAL_BASIS_KERNEL_EVAL_DEFINES_SVH

// Next-cycle implication, switched off while reset is high.
`define RBK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define RBK_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rbk_pkg.sv @@
// ----------------------------------------------------------------------------
// Radial basis kernel evaluator: package
// Constants, codes and the command and status bundles shared by the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rbk_pkg;

  localparam int MAX_DIMENSIONS_DEF = 16;

  // Largest single squared-difference term, floor((2^32-1)^2 / 2^16).
  localparam logic [47:0] TERM_MAX  = 48'hFFFF_FFFE_0000;
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [23:0] EPS_RESET = 24'h01_0000;
  localparam logic [16:0] ONE_Q16   = 17'h1_0000;
  localparam logic [48:0] R_CLIP    = 49'h1_0000_0000_0000;
  localparam logic [3:0]  TAYLOR_K  = 4'd13;

  localparam logic [5:0] RMUL_STEPS = 6'd3;
  localparam logic [5:0] SQRT_STEPS = 6'd31;
  localparam logic [5:0] DIV_STEPS  = 6'd32;

  typedef enum logic [1:0] {
    KIND_GAUSS = 2'd0,
    KIND_MQ    = 2'd1,
    KIND_IQ    = 2'd2,
    KIND_IMQ   = 2'd3
  } kind_t;

  typedef enum logic {
    REG_KIND = 1'b0,
    REG_EPS  = 1'b1
  } reg_idx_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SQR, OP_ADD, OP_EPS, OP_RMUL, OP_RFIN,
    OP_GINIT, OP_GRED, OP_TINIT, OP_TMUL, OP_DIV, OP_TACC,
    OP_SQINIT, OP_SQ, OP_DINIT_U, OP_DINIT_S,
    OP_RES_GAUSS, OP_RES_Q, OP_RES_SQ, OP_RES_ZERO, OP_RES_SAT, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic  last;
    logic  r_big;
    logic  u_big;
    logic  red_ge;
    logic  k_last;
    kind_t kind;
  } stat_t;

endpackage

`default_nettype wire

@@ rtl/rbk_ctrl.sv @@
// ----------------------------------------------------------------------------
// Radial basis kernel evaluator: controller
// Sequences accumulation, scaling and the iterative kernel units.
// ----------------------------------------------------------------------------
`default_nettype none

module rbk_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire rbk_pkg::stat_t stat,
  output rbk_pkg::cmd_t      cmd
);

  typedef enum logic [16:0] {
    ST_IDLE = 17'h00001,
    ST_SQR  = 17'h00002,
    ST_ADD  = 17'h00004,
    ST_EPS  = 17'h00008,
    ST_RMUL = 17'h00010,
    ST_RFIN = 17'h00020,
    ST_DISP = 17'h00040,
    ST_GRED = 17'h00080,
    ST_TMUL = 17'h00100,
    ST_DIV  = 17'h00200,
    ST_TACC = 17'h00400,
    ST_GRND = 17'h00800,
    ST_SQRT = 17'h01000,
    ST_RESS = 17'h02000,
    ST_DINS = 17'h04000,
    ST_RESQ = 17'h08000,
    ST_OUT  = 17'h10000
  } state_t;

  state_t     state, state_next;
  logic [5:0] cnt, cnt_next;
  logic       emit;

  assign in_ready = (state == ST_IDLE);
  assign emit     = (state == ST_OUT) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd.op     = rbk_pkg::OP_NONE;
    cmd.idx    = cnt[1:0];
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = rbk_pkg::OP_LOAD;
          state_next = ST_SQR;
        end
      end
      ST_SQR: begin
        cmd.op     = rbk_pkg::OP_SQR;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.op     = rbk_pkg::OP_ADD;
        state_next = stat.last ? ST_EPS : ST_IDLE;
      end
      ST_EPS: begin
        cmd.op     = rbk_pkg::OP_EPS;
        cnt_next   = rbk_pkg::RMUL_STEPS;
        state_next = ST_RMUL;
      end
      ST_RMUL: begin
        cmd.op = rbk_pkg::OP_RMUL;
        if (cnt == 6'd0) begin
          state_next = ST_RFIN;
        end else begin
          cnt_next = cnt - 6'd1;
        end
      end
      ST_RFIN: begin
        cmd.op     = rbk_pkg::OP_RFIN;
        state_next = ST_DISP;
      end
      ST_DISP: begin
        case (stat.kind)
          rbk_pkg::KIND_GAUSS: begin
            if (stat.r_big) begin
              cmd.op     = rbk_pkg::OP_RES_ZERO;
              state_next = ST_OUT;
            end else begin
              cmd.op     = rbk_pkg::OP_GINIT;
              state_next = ST_GRED;
            end
          end
          rbk_pkg::KIND_IQ: begin
            cmd.op     = rbk_pkg::OP_DINIT_U;
            cnt_next   = rbk_pkg::DIV_STEPS;
            state_next = ST_DIV;
          end
          default: begin
            if (stat.u_big) begin
              cmd.op     = (stat.kind == rbk_pkg::KIND_MQ) ? rbk_pkg::OP_RES_SAT
                                                          : rbk_pkg::OP_RES_ZERO;
              state_next = ST_OUT;
            end else begin
              cmd.op     = rbk_pkg::OP_SQINIT;
              cnt_next   = rbk_pkg::SQRT_STEPS;
              state_next = ST_SQRT;
            end
          end
        endcase
      end
      ST_GRED: begin
        if (stat.red_ge) begin
          cmd.op = rbk_pkg::OP_GRED;
        end else begin
          cmd.op     = rbk_pkg::OP_TINIT;
          state_next = ST_TMUL;
        end
      end
      ST_TMUL: begin
        cmd.op     = rbk_pkg::OP_TMUL;
        cnt_next   = rbk_pkg::DIV_STEPS;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.op = rbk_pkg::OP_DIV;
        if (cnt == 6'd0) begin
          state_next = (stat.kind == rbk_pkg::KIND_GAUSS) ? ST_TACC : ST_RESQ;
        end else begin
          cnt_next = cnt - 6'd1;
        end
      end
      ST_TACC: begin
        cmd.op     = rbk_pkg::OP_TACC;
        state_next = stat.k_last ? ST_GRND : ST_TMUL;
      end
      ST_GRND: begin
        cmd.op     = rbk_pkg::OP_RES_GAUSS;
        state_next = ST_OUT;
      end
      ST_SQRT: begin
        cmd.op = rbk_pkg::OP_SQ;
        if (cnt == 6'd0) begin
          state_next = (stat.kind == rbk_pkg::KIND_MQ) ? ST_RESS : ST_DINS;
        end else begin
          cnt_next = cnt - 6'd1;
        end
      end
      ST_RESS: begin
        cmd.op     = rbk_pkg::OP_RES_SQ;
        state_next = ST_OUT;
      end
      ST_DINS: begin
        cmd.op     = rbk_pkg::OP_DINIT_S;
        cnt_next   = rbk_pkg::DIV_STEPS;
        state_next = ST_DIV;
      end
      ST_RESQ: begin
        cmd.op     = rbk_pkg::OP_RES_Q;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (emit) begin
          cmd.op     = rbk_pkg::OP_EMIT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= 6'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/rbk_dp.sv @@
// ----------------------------------------------------------------------------
// Radial basis kernel evaluator: datapath
// Accumulator, scaling multiplier, range reduction, Taylor series, square
// root and restoring divider, with the configuration and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rbk_dp #(
  parameter int MAX_DIMENSIONS = rbk_pkg::MAX_DIMENSIONS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_we,
  input  wire logic           cfg_index,
  input  wire logic [23:0]    cfg_data,
  input  wire logic [31:0]    coord_query,
  input  wire logic [31:0]    coord_center,
  input  wire logic           last_coord,
  input  wire rbk_pkg::cmd_t  cmd,
  output rbk_pkg::stat_t      stat,
  output logic [31:0]         kernel_value,
  output logic                saturated
);

  localparam logic [63:0] SUM_LIMIT =
    64'(MAX_DIMENSIONS) * {16'd0, rbk_pkg::TERM_MAX};

  rbk_pkg::kind_t kind;
  logic [23:0]  eps;
  logic [63:0]  sum;
  logic         ovf;

  logic [31:0]  mag;
  logic         last_q;
  logic [47:0]  term;
  logic [47:0]  eps2;
  logic [111:0] acc;
  logic [48:0]  r, u;
  logic         ovf_cap;
  logic [35:0]  gx;
  logic [4:0]   gn;
  logic [32:0]  term_g;
  logic [39:0]  e_acc;
  logic [3:0]   gk;
  logic [32:0]  dvd, quo;
  logic [48:0]  dvs, rem;
  logic [63:0]  sv, sres, sbit;
  logic [31:0]  res_val;
  logic         res_sat;

  logic signed [32:0] diff;
  logic [63:0]  sum_new;
  logic [31:0]  a_part;
  logic [23:0]  b_part;
  logic [55:0]  pp;
  logic [111:0] pp_sh;
  logic [79:0]  hi;
  logic [48:0]  r_new;
  logic [64:0]  tprod;
  logic [49:0]  rem_sh, rem_nx;
  logic         div_ge;
  logic [63:0]  sq_t;
  logic         sq_ge;
  logic [5:0]   shamt;
  logic [40:0]  rnd, g_val;

  always_comb begin
    diff    = {coord_query[31], coord_query} - {coord_center[31], coord_center};
    sum_new = sum + {16'd0, term};
    a_part  = cmd.idx[0] ? sum[63:32] : sum[31:0];
    b_part  = cmd.idx[1] ? eps2[47:24] : eps2[23:0];
    pp      = {24'd0, a_part} * {32'd0, b_part};
    case (cmd.idx)
      2'd0:    pp_sh = {56'd0, pp};
      2'd1:    pp_sh = {24'd0, pp, 32'd0};
      2'd2:    pp_sh = {32'd0, pp, 24'd0};
      default: pp_sh = {pp, 56'd0};
    endcase
    hi     = acc[111:32];
    r_new  = (hi > {31'd0, rbk_pkg::R_CLIP}) ? rbk_pkg::R_CLIP : hi[48:0];
    tprod  = {32'd0, term_g} * {33'd0, gx[31:0]};
    rem_sh = {rem, dvd[32]};
    div_ge = rem_sh >= {1'b0, dvs};
    rem_nx = div_ge ? rem_sh - {1'b0, dvs} : rem_sh;
    sq_t   = sres + sbit;
    sq_ge  = sv >= sq_t;
    shamt  = {1'b0, gn} + 6'd16;
    rnd    = {1'b0, e_acc} + (41'd1 << (shamt - 6'd1));
    g_val  = rnd >> shamt;
  end

  assign stat.last   = last_q;
  assign stat.r_big  = |r[48:20];
  assign stat.u_big  = u[48];
  assign stat.red_ge = gx >= {4'd0, rbk_pkg::LN2_Q32};
  assign stat.k_last = (gk == rbk_pkg::TAYLOR_K);
  assign stat.kind   = kind;

  // Configuration, the running sum and its overflow mark.
  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= rbk_pkg::KIND_GAUSS;
      eps  <= rbk_pkg::EPS_RESET;
      sum  <= 64'd0;
      ovf  <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == rbk_pkg::REG_KIND) begin
          kind <= rbk_pkg::kind_t'(cfg_data[1:0]);
        end else begin
          eps <= cfg_data;
        end
      end
      if (cmd.op == rbk_pkg::OP_ADD) begin
        if (sum_new > SUM_LIMIT) begin
          sum <= SUM_LIMIT;
          ovf <= 1'b1;
        end else begin
          sum <= sum_new;
        end
      end else if (cmd.op == rbk_pkg::OP_RFIN) begin
        sum <= 64'd0;
        ovf <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      rbk_pkg::OP_LOAD: begin
        mag    <= diff[32] ? 32'(-diff) : diff[31:0];
        last_q <= last_coord;
      end
      rbk_pkg::OP_SQR: begin
        term <= 48'(({32'd0, mag} * {32'd0, mag}) >> 16);
      end
      rbk_pkg::OP_EPS: begin
        eps2    <= {24'd0, eps} * {24'd0, eps};
        acc     <= 112'd0;
        ovf_cap <= ovf;
      end
      rbk_pkg::OP_RMUL: begin
        acc <= acc + pp_sh;
      end
      rbk_pkg::OP_RFIN: begin
        r <= r_new;
        u <= r_new + {32'd0, rbk_pkg::ONE_Q16};
      end
      rbk_pkg::OP_GINIT: begin
        gx <= {r[19:0], 16'd0};
        gn <= 5'd0;
      end
      rbk_pkg::OP_GRED: begin
        gx <= gx - {4'd0, rbk_pkg::LN2_Q32};
        gn <= gn + 5'd1;
      end
      rbk_pkg::OP_TINIT: begin
        term_g <= {1'b1, 32'd0};
        e_acc  <= {8'd1, 32'd0};
        gk     <= 4'd1;
      end
      rbk_pkg::OP_TMUL: begin
        dvd <= tprod[64:32];
        dvs <= {45'd0, gk};
        rem <= 49'd0;
      end
      rbk_pkg::OP_DIV: begin
        dvd <= {dvd[31:0], 1'b0};
        rem <= rem_nx[48:0];
        quo <= {quo[31:0], div_ge};
      end
      rbk_pkg::OP_TACC: begin
        term_g <= quo;
        // Odd powers of the series carry a minus sign.
        e_acc  <= gk[0] ? e_acc - {7'd0, quo} : e_acc + {7'd0, quo};
        gk     <= gk + 4'd1;
      end
      rbk_pkg::OP_SQINIT: begin
        sv   <= {u[47:0], 16'd0};
        sres <= 64'd0;
        sbit <= {2'b01, 62'd0};
      end
      rbk_pkg::OP_SQ: begin
        if (sq_ge) begin
          sv   <= sv - sq_t;
          sres <= (sres >> 1) + sbit;
        end else begin
          sres <= sres >> 1;
        end
        sbit <= sbit >> 2;
      end
      rbk_pkg::OP_DINIT_U: begin
        dvd <= {1'b1, 32'd0};
        dvs <= u;
        rem <= 49'd0;
      end
      rbk_pkg::OP_DINIT_S: begin
        dvd <= {1'b1, 32'd0};
        dvs <= {17'd0, sres[31:0]};
        rem <= 49'd0;
      end
      rbk_pkg::OP_RES_GAUSS: begin
        res_val <= g_val[31:0];
        res_sat <= ovf_cap;
      end
      rbk_pkg::OP_RES_Q: begin
        res_val <= quo[31:0];
        res_sat <= ovf_cap;
      end
      rbk_pkg::OP_RES_SQ: begin
        res_val <= sres[31:0];
        res_sat <= ovf_cap;
      end
      rbk_pkg::OP_RES_ZERO: begin
        res_val <= 32'd0;
        res_sat <= ovf_cap;
      end
      rbk_pkg::OP_RES_SAT: begin
        res_val <= 32'hFFFF_FFFF;
        res_sat <= 1'b1;
      end
      rbk_pkg::OP_EMIT: begin
        kernel_value <= res_val;
        saturated    <= res_sat;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/radial_basis_kernel_eval.sv @@
// ----------------------------------------------------------------------------
// Radial basis kernel evaluator
// Accumulates squared coordinate differences of two points and, on the
// last coordinate, evaluates a Gaussian, multiquadric, inverse quadratic or
// inverse multiquadric kernel of the scaled distance.
//
//   Channel   Direction  Contents
//   s_axis    in         tdata: coord_query, coord_center; tlast: last_coord
//   m_axis    out        tdata: kernel_value; tuser: saturated
//   cfg       in         index 0 kernel_kind, index 1 shape_epsilon
//
// Each coordinate beat occupies the block for load, square and add steps.
// A last beat then goes through scaling and dispatch, then the divide, the
// square root, both, or the Gaussian range reduction and Taylor series in
// the shared divider, and finally a result step and a hand-off to the
// output register.
// Reset is synchronous and clears the sum; a result waits in the output
// register while the next point's coordinates are taken, and the block only
// stalls when that register is still full as the following result is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module radial_basis_kernel_eval #(
  parameter int MAX_DIMENSIONS = rbk_pkg::MAX_DIMENSIONS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // coord_query [31:0], coord_center [63:32]
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // kernel_value [31:0]
  output logic             m_axis_tuser,  // saturated [0]
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [23:0] cfg_data
);

  rbk_pkg::cmd_t  cmd;
  rbk_pkg::stat_t stat;

  rbk_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rbk_dp #(
    .MAX_DIMENSIONS (MAX_DIMENSIONS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .coord_query  (s_axis_tdata[31:0]),
    .coord_center (s_axis_tdata[63:32]),
    .last_coord   (s_axis_tlast),
    .cmd          (cmd),
    .stat         (stat),
    .kernel_value (m_axis_tdata),
    .saturated    (m_axis_tuser)
  );

endmodule

`default_nettype wire

@@ rtl/rbk_chk.sv @@
// ----------------------------------------------------------------------------
// Radial basis kernel evaluator: port checker
// Watches the top-level ports and is bound to every instance of the block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "radial_basis_kernel_eval_defines.svh"

module rbk_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  // A held result beat keeps its value until it is taken.
  `RBK_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result beat changed while stalled")

  // Every accepted coordinate needs further cycles before the next one.
  `RBK_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready straight after an accepted beat")

  `RBK_ASSERT_NEXT_ALWAYS(a_rst_no_out, rst, !m_axis_tvalid, "result valid after reset")

  `RBK_ASSERT_NEXT_ALWAYS(a_rst_ready, rst, s_axis_tready, "input not ready after reset")

endmodule

bind radial_basis_kernel_eval rbk_chk u_rbk_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ tb/sv/tb_radial_basis_kernel_eval.sv @@
// ----------------------------------------------------------------------------
// Radial basis kernel evaluator testbench
// Streams coordinate pairs under several kernel and epsilon settings, with
// random idling on both sides, and compares every kernel beat with values
// worked out by an independent fixed-point predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct {
  logic [31:0] value;
  logic        sat;
} kernel_beat_t;

class rbk_scoreboard;
  localparam int MAX_DIMS = 16;
  kernel_beat_t    pending[$];
  logic [63:0]     dist_sum;
  bit              overflowed;
  rbk_pkg::kind_t  kind;
  logic [23:0]     eps;
  int              errors;

  function new();
    dist_sum   = '0;
    overflowed = 0;
    kind       = rbk_pkg::KIND_GAUSS;
    eps        = rbk_pkg::EPS_RESET;
    errors     = 0;
  endfunction

  function void set_reg(rbk_pkg::reg_idx_t idx, logic [23:0] d);
    if (idx == rbk_pkg::REG_KIND) kind = rbk_pkg::kind_t'(d[1:0]);
    else eps = d;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = '0;
    b   = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // exp(-r) by range reduction over ln 2 and a Taylor series to the 13th power.
  function automatic logic [63:0] gauss(logic [63:0] r);
    logic [63:0] x, n, f, term, pos, neg, e, shift;
    if (r >= (64'h1 << 20)) return '0;
    x    = r << 16;
    n    = x / rbk_pkg::LN2_Q32;
    f    = x - n * rbk_pkg::LN2_Q32;
    term = 64'h1 << 32;
    pos  = term;
    neg  = '0;
    for (int k = 1; k <= 13; k++) begin
      term = ((term * f) >> 32) / k;
      if (k % 2) neg = neg + term;
      else pos = pos + term;
    end
    e     = pos - neg;
    shift = n + 16;
    return (e + (64'h1 << (shift - 1))) >> shift;
  endfunction

  function void note(logic [31:0] q, logic [31:0] c, bit last);
    logic signed [32:0] d;
    logic [63:0]        mag, eps2, r, u, val, lim;
    logic [127:0]       prod;
    bit                 clip;
    kernel_beat_t       b;
    d   = $signed({q[31], q}) - $signed({c[31], c});
    mag = d[32] ? 64'(-d) : 64'(d);
    lim = 64'(MAX_DIMS) * 64'(rbk_pkg::TERM_MAX);
    dist_sum = dist_sum + ((mag * mag) >> 16);
    if (dist_sum > lim) begin
      dist_sum   = lim;
      overflowed = 1;
    end
    if (!last) return;
    eps2 = 64'(eps) * 64'(eps);
    prod = {64'b0, dist_sum} * {64'b0, eps2};
    r    = (prod[127:96] != 0) ? '1 : prod[95:32];
    if (r > 64'(rbk_pkg::R_CLIP)) r = 64'(rbk_pkg::R_CLIP);
    u    = r + 64'(rbk_pkg::ONE_Q16);
    clip = 0;
    case (kind)
      rbk_pkg::KIND_GAUSS: val = gauss(r);
      rbk_pkg::KIND_MQ: begin
        if (u >= 64'(rbk_pkg::R_CLIP)) begin
          val  = 64'hFFFF_FFFF;
          clip = 1;
        end else begin
          val = int_sqrt(u << 16);
        end
      end
      rbk_pkg::KIND_IQ: val = (64'h1 << 32) / u;
      default: val = (u >= 64'(rbk_pkg::R_CLIP)) ? '0 : (64'h1 << 32) / int_sqrt(u << 16);
    endcase
    b.value = val[31:0];
    b.sat   = overflowed | clip;
    pending = {pending, b};
    dist_sum   = '0;
    overflowed = 0;
  endfunction

  function void check(logic [31:0] v, logic s);
    kernel_beat_t b;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected kernel beat: value %h sat %b", v, s);
      return;
    end
    b = pending.pop_front();
    if (v !== b.value || s !== b.sat) begin
      errors++;
      if (errors <= 10)
        $display("kernel beat wrong: expected value %h sat %b, got value %h sat %b",
                 b.value, b.sat, v, s);
    end
  endfunction
endclass

module tb_radial_basis_kernel_eval;
  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we;
  logic        cfg_index;
  logic [23:0] cfg_data;

  rbk_scoreboard sb = new();
  bit quiet = 0;
  int sent;

  radial_basis_kernel_eval DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("radial_basis_kernel_eval: mismatch");
    $finish;
  end

  always @(posedge clk) begin
    m_axis_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 28);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata, m_axis_tuser);
  end

  task automatic send_coord(logic [31:0] q, logic [31:0] c, bit last);
    if (!quiet) begin
      while ($urandom_range(99) < 28) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {c, q};
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    sb.note(q, c, last);
    sent++;
  endtask

  task automatic write_reg(rbk_pkg::reg_idx_t idx, logic [23:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    sb.set_reg(idx, d);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // The Gaussian path keeps the block busy longest.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic random_point();
    int dims;
    bit wide;
    logic [31:0] q, c;
    if ($urandom_range(99) < 5) begin
      // Enough worst-case terms to overflow the accumulator.
      dims = $urandom_range(20, 17);
      for (int i = 0; i < dims; i++) begin
        if ($urandom_range(1)) send_coord(32'h7FFF_FFFF, 32'h8000_0000, i == dims - 1);
        else send_coord(32'h8000_0000, 32'h7FFF_FFFF, i == dims - 1);
      end
    end else begin
      dims = $urandom_range(4, 1);
      wide = $urandom_range(1);
      for (int i = 0; i < dims; i++) begin
        if (wide) begin
          q = $urandom;
          c = $urandom;
        end else begin
          q = 32'($signed(20'($urandom)));
          c = 32'($signed(20'($urandom)));
        end
        send_coord(q, c, i == dims - 1);
      end
    end
  endtask

  initial begin
    logic [1:0]  kinds[8] = '{0, 1, 2, 3, 0, 1, 3, 2};
    logic [23:0] epss[8]  = '{24'h01_0000, 24'hFF_FFFF, 24'h00_0000, 24'hFF_FFFF,
                              24'h01_0000, 24'h01_0000, 24'h00_4000, 24'h01_0000};
    logic [23:0] e;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = rbk_pkg::REG_KIND;
    cfg_data      = '0;
    sent          = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings first: unit epsilon, Gaussian.
    send_coord(32'h0001_0000, 32'h0000_0000, 1);
    send_coord(32'h1234_5678, 32'h1234_5678, 1);
    send_coord(32'h0000_8000, 32'hFFFF_8000, 0);
    send_coord(32'hFFFF_0000, 32'h0000_0000, 1);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      e = epss[ph];
      if (ph >= 4 && $urandom_range(1)) e = 24'($urandom_range(24'h03_FFFF));
      write_reg(rbk_pkg::REG_KIND, {22'($urandom), kinds[ph]});
      write_reg(rbk_pkg::REG_EPS, e);
      quiet = (ph == 3);
      // Extreme differences in both directions, and a zero one.
      send_coord(32'h7FFF_FFFF, 32'h8000_0000, 1);
      send_coord(32'h8000_0000, 32'h7FFF_FFFF, 1);
      send_coord(32'h8000_0000, 32'h8000_0000, 1);
      sent = 0;
      while (sent < 225) random_point();
      drain();
    end

    quiet = 1'b0;
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("radial_basis_kernel_eval: match");
    end else begin
      $display("radial_basis_kernel_eval: mismatch");
    end
    $finish;
  end
endmodule
